// File: design/mks_pkg.sv
// Package for the matrix keypad scanner: field widths, scan mode codes,
// constants and the column drive pattern table.
// No dependencies.
`default_nettype none

package mks_pkg;

    localparam int RETURN_W   = 3;
    localparam int DRIVE_W    = 3;
    localparam int CODE_W     = 8;
    localparam int COUNT_W    = 16;
    localparam int ROW_W      = 3;
    localparam int COL_W      = 4;
    localparam int PHASE_W    = 2;

    localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 16'd10;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 16'hffff;
    localparam logic [CODE_W-1:0]  INVALID_CODE   = 8'hff;
    localparam logic [DRIVE_W-1:0] ALL_LOW        = 3'b000;
    localparam logic [PHASE_W-1:0] LAST_PHASE     = 2'd3;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_DEBOUNCE,
        MODE_SCAN,
        MODE_RELEASE
    } mode_t;

    // scan line levels while column phase p is read
    function automatic logic [DRIVE_W-1:0] phase_drive(input logic [PHASE_W-1:0] phase);
        logic [DRIVE_W-1:0] drive;
        case (phase)
            2'd0:    drive = 3'b111;   // all high, fourth column tied low
            2'd1:    drive = 3'b011;   // scan3 low
            2'd2:    drive = 3'b101;   // scan2 low
            2'd3:    drive = 3'b110;   // scan1 low
            default: drive = 3'b111;
        endcase
        return drive;
    endfunction

endpackage

`default_nettype wire

// File: design/mks_ifs.sv
// Channel interfaces of the matrix keypad scanner: return line samples in,
// scan results out, debounce length configuration writes.
// Depends on mks_pkg.
`default_nettype none

interface mks_keys_if;
    logic                          valid;
    logic                          ready;
    logic [mks_pkg::RETURN_W-1:0]  return_lines;

    modport source (output valid, output return_lines, input ready);
    modport sink   (input valid, input return_lines, output ready);
endinterface

interface mks_result_if;
    logic                          valid;
    logic                          ready;
    logic [mks_pkg::DRIVE_W-1:0]   scan_drive;
    logic                          key_event;
    logic [mks_pkg::CODE_W-1:0]    key_code;
    logic                          key_error;

    modport source (output valid, output scan_drive, output key_event,
                    output key_code, output key_error, input ready);
    modport sink   (input valid, input scan_drive, input key_event,
                    input key_code, input key_error, output ready);
endinterface

interface mks_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mks_pkg::COUNT_W-1:0]   debounce_ticks;

    modport source (output valid, output debounce_ticks, input ready);
    modport sink   (input valid, input debounce_ticks, output ready);
endinterface

`default_nettype wire

// File: design/matrix_keypad_scanner.sv
// Top level of the debounced 3x4 matrix keypad scanner.
// Depends on mks_pkg and the channel interfaces in mks_ifs.sv.
//
//   channel  | dir | payload                                      | handshake
//   ---------+-----+----------------------------------------------+------------
//   keys     | in  | return_lines[2:0]                            | valid/ready
//   result   | out | scan_drive[2:0] key_event key_code[7:0] key_error | valid/ready
//   cfg      | in  | debounce_ticks[15:0]                         | valid/ready
//
// One request per cycle while keys.ready is high; its result is in the
// output register in the cycle after acceptance. The scan state and the
// result register update in the same cycle from one pass through the mode logic.
// keys.ready drops only while a result waits and result.ready is low.
// Reset clears the mode, counters and masks; debounce_ticks returns to 10.
// cfg.ready is always high.
`default_nettype none

module matrix_keypad_scanner (
    input  wire logic           clk,
    input  wire logic           rst_n,
    mks_keys_if.sink            keys,
    mks_result_if.source        result,
    mks_cfg_if.sink             cfg
);

    mks_pkg::mode_t                    mode_reg, mode_next;
    logic [mks_pkg::COUNT_W-1:0]       debounce_reg;
    logic [mks_pkg::COUNT_W-1:0]       tick_count_reg, tick_count_next;
    logic [mks_pkg::ROW_W-1:0]         row_mask_reg, row_mask_next;
    logic [mks_pkg::COL_W-1:0]         column_mask_reg, column_mask_next;
    logic [mks_pkg::PHASE_W-1:0]       phase_reg, phase_next;

    logic                              res_valid_reg;
    logic [mks_pkg::DRIVE_W-1:0]       drive_reg, drive_next;
    logic                              event_reg, event_next;
    logic [mks_pkg::CODE_W-1:0]        code_reg, code_next;
    logic                              error_reg, error_next;

    logic                              accept;
    logic [mks_pkg::ROW_W-1:0]         low;
    logic [mks_pkg::COL_W-1:0]         column_set;

    assign keys.ready = !res_valid_reg || result.ready;
    assign accept     = keys.valid && keys.ready;
    assign cfg.ready  = 1'b1;

    assign low = ~keys.return_lines;

    always_comb
    begin
        mode_next        = mode_reg;
        tick_count_next  = tick_count_reg;
        row_mask_next    = row_mask_reg;
        column_mask_next = column_mask_reg;
        phase_next       = phase_reg;
        drive_next       = mks_pkg::ALL_LOW;
        event_next       = 1'b0;
        code_next        = '0;
        error_next       = 1'b0;
        column_set       = column_mask_reg;
        if ((low & row_mask_reg) != '0)
        begin
            column_set = column_mask_reg | (mks_pkg::COL_W'(1) << phase_reg);
        end

        case (mode_reg)
            mks_pkg::MODE_DEBOUNCE:
            begin
                if (tick_count_reg != mks_pkg::COUNT_MAX)
                begin
                    tick_count_next = tick_count_reg + 1'b1;
                end
                if (tick_count_next >= debounce_reg)
                begin
                    if (low == '0)
                    begin
                        mode_next = mks_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        row_mask_next    = low;
                        column_mask_next = '0;
                        phase_next       = '0;
                        mode_next        = mks_pkg::MODE_SCAN;
                        drive_next       = mks_pkg::phase_drive('0);
                    end
                end
            end
            mks_pkg::MODE_SCAN:
            begin
                column_mask_next = column_set;
                if (phase_reg != mks_pkg::LAST_PHASE)
                begin
                    phase_next = phase_reg + 1'b1;
                    drive_next = mks_pkg::phase_drive(phase_next);
                end
                else
                begin
                    event_next = 1'b1;
                    phase_next = '0;
                    if (row_mask_reg == '0 || column_set == '0)
                    begin
                        code_next  = mks_pkg::INVALID_CODE;
                        error_next = 1'b1;
                        mode_next  = mks_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        code_next = {1'b0, row_mask_reg, column_set};
                        mode_next = mks_pkg::MODE_RELEASE;
                    end
                end
            end
            mks_pkg::MODE_RELEASE:
            begin
                if (low == '0)
                begin
                    mode_next = mks_pkg::MODE_IDLE;
                end
            end
            default:
            begin
                mode_next = mks_pkg::MODE_IDLE;
                if (low != '0)
                begin
                    tick_count_next = '0;
                    mode_next       = mks_pkg::MODE_DEBOUNCE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= mks_pkg::MODE_IDLE;
            tick_count_reg  <= '0;
            row_mask_reg    <= '0;
            column_mask_reg <= '0;
            phase_reg       <= '0;
            debounce_reg    <= mks_pkg::DEBOUNCE_RESET;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                debounce_reg <= cfg.debounce_ticks;
            end
            if (accept)
            begin
                mode_reg        <= mode_next;
                tick_count_reg  <= tick_count_next;
                row_mask_reg    <= row_mask_next;
                column_mask_reg <= column_mask_next;
                phase_reg       <= phase_next;
                res_valid_reg   <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            drive_reg <= drive_next;
            event_reg <= event_next;
            code_reg  <= code_next;
            error_reg <= error_next;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.scan_drive = drive_reg;
    assign result.key_event  = event_reg;
    assign result.key_code   = code_reg;
    assign result.key_error  = error_reg;

endmodule

`default_nettype wire

// File: design/mks_checker.sv
// Port-level checks for the matrix keypad scanner, bound to the top level.
// Depends on mks_pkg and matrix_keypad_scanner.
`default_nettype none

module mks_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         res_valid,
    input wire logic                         res_ready,
    input wire logic [mks_pkg::DRIVE_W-1:0]  scan_drive,
    input wire logic                         key_event,
    input wire logic [mks_pkg::CODE_W-1:0]   key_code,
    input wire logic                         key_error
);

    // an error report always carries the invalid code
    a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && key_error |-> key_event && key_code == mks_pkg::INVALID_CODE)
        else $error("key_error without event or invalid code");

    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !key_event |-> key_code == '0 && !key_error)
        else $error("code or error set without key_event");

    // a good report has a row and a column and leaves the lines low for polling
    a_good_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && key_event && !key_error |->
            key_code[7] == 1'b0 && key_code[6:4] != '0 && key_code[3:0] != '0
            && scan_drive == mks_pkg::ALL_LOW)
        else $error("malformed key report");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(scan_drive)
            && $stable(key_event) && $stable(key_code) && $stable(key_error))
        else $error("stalled result changed");

endmodule

bind matrix_keypad_scanner mks_checker u_mks_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .scan_drive (result.scan_drive),
    .key_event  (result.key_event),
    .key_code   (result.key_code),
    .key_error  (result.key_error)
);

`default_nettype wire
